// ===== hdl/i2cmra_pkg.sv =====
// Package for the I2C register access master: beat types, phase codes and constants.
// No dependencies.
`default_nettype none
package i2cmra_pkg;
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] slave_addr;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} in_beat_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic       ack_error;
		logic [7:0] read_data;
	} out_beat_t;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [9:0] ACK_LIMIT_RESET = 10'd500;

	localparam logic [4:0] PH_IDLE = 5'd0;
	localparam logic [4:0] PH_ST_SETUP = 5'd1;
	localparam logic [4:0] PH_ST_FALL = 5'd2;
	localparam logic [4:0] PH_ST_HOLD = 5'd3;
	localparam logic [4:0] PH_TX_LOW = 5'd4;
	localparam logic [4:0] PH_TX_HIGH = 5'd5;
	localparam logic [4:0] PH_ACK_LOW = 5'd6;
	localparam logic [4:0] PH_ACK_HIGH = 5'd7;
	localparam logic [4:0] PH_ACK_END = 5'd8;
	localparam logic [4:0] PH_RS_PREP = 5'd9;
	localparam logic [4:0] PH_RX_LOW = 5'd10;
	localparam logic [4:0] PH_RX_HIGH = 5'd11;
	localparam logic [4:0] PH_NACK_LOW = 5'd12;
	localparam logic [4:0] PH_NACK_HIGH = 5'd13;
	localparam logic [4:0] PH_SP_A = 5'd14;
	localparam logic [4:0] PH_SP_B = 5'd15;
	localparam logic [4:0] PH_SP_C = 5'd16;
	localparam logic [4:0] PH_SP_D = 5'd17;

	localparam logic [1:0] BI_ADDR = 2'd0;
	localparam logic [1:0] BI_REG  = 2'd1;
	localparam logic [1:0] BI_DATA = 2'd2;
	localparam logic [1:0] BI_RADDR = 2'd3;

	localparam int QUEUE_DEPTH = 2;
endpackage
`default_nettype wire

// ===== hdl/i2c_master_register_access.sv =====
// Top level of the I2C register access master; ties front, queue and back together.
// Depends on i2cmra_pkg, i2cmra_front, i2cmra_queue and i2cmra_back.
// Each input beat is one bus phase tick and gives exactly one result beat. A new beat is
// taken every clock cycle while the receiver keeps up; a beat passes the front register,
// the two-entry queue and the sequencer register in that order before its result appears
// at the output.
`default_nettype none
module i2c_master_register_access (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire i2cmra_pkg::in_beat_t  in_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output i2cmra_pkg::out_beat_t      out_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	input  wire logic [9:0]            cfg_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready
);
	i2cmra_pkg::in_beat_t cls_data, q_data;
	logic cls_valid, cls_ready, q_valid, q_ready;
	logic [9:0] ack_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ack_limit_q <= i2cmra_pkg::ACK_LIMIT_RESET;
		else if (cfg_valid) ack_limit_q <= cfg_data;
	end

	i2cmra_front u_front (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .in_valid(in_valid),
		.in_ready(in_ready), .cls_data(cls_data), .cls_valid(cls_valid),
		.cls_ready(cls_ready)
	);

	i2cmra_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_data(cls_data), .wr_valid(cls_valid),
		.wr_ready(cls_ready), .rd_data(q_data), .rd_valid(q_valid), .rd_ready(q_ready)
	);

	i2cmra_back u_back (
		.clk(clk), .arst_n(arst_n), .q_data(q_data), .q_valid(q_valid),
		.q_ready(q_ready), .ack_limit(ack_limit_q), .out_data(out_data),
		.out_valid(out_valid), .out_ready(out_ready)
	);
endmodule
`default_nettype wire

// ===== hdl/i2cmra_queue.sv =====
// Two-entry beat queue between the front and the back of the I2C master.
// Depends on i2cmra_pkg.
`default_nettype none
module i2cmra_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire i2cmra_pkg::in_beat_t wr_data,
	input  wire logic                 wr_valid,
	output logic                      wr_ready,
	output i2cmra_pkg::in_beat_t      rd_data,
	output logic                      rd_valid,
	input  wire logic                 rd_ready
);
	i2cmra_pkg::in_beat_t entry_q [i2cmra_pkg::QUEUE_DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	logic pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data = entry_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== hdl/i2cmra_front.sv =====
// Front part: accepts input beats and classifies the command code.
// Depends on i2cmra_pkg.
`default_nettype none
module i2cmra_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire i2cmra_pkg::in_beat_t in_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output i2cmra_pkg::in_beat_t      cls_data,
	output logic                      cls_valid,
	input  wire logic                 cls_ready
);
	i2cmra_pkg::in_beat_t beat_s1;
	i2cmra_pkg::in_beat_t in_beat;
	logic valid_s1;

	assign in_ready = !valid_s1 || cls_ready;
	assign cls_data = beat_s1;
	assign cls_valid = valid_s1;

	always_comb begin
		in_beat = in_data;
		// Code 3 means nothing and is reduced to a plain tick.
		if (in_data.cmd != i2cmra_pkg::CMD_WRITE && in_data.cmd != i2cmra_pkg::CMD_READ)
			in_beat.cmd = i2cmra_pkg::CMD_TICK;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= in_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/i2cmra_back.sv =====
// Back part: the bus phase sequencer, one phase per beat, with an output register.
// Depends on i2cmra_pkg.
`default_nettype none
module i2cmra_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire i2cmra_pkg::in_beat_t q_data,
	input  wire logic                 q_valid,
	output logic                      q_ready,
	input  wire logic [9:0]           ack_limit,
	output i2cmra_pkg::out_beat_t     out_data,
	output logic                      out_valid,
	input  wire logic                 out_ready
);
	logic [4:0] phase_q;
	logic [3:0] bit_count_q;
	logic [7:0] shift_q;
	logic [9:0] wait_q;
	logic       is_read_q;
	logic [7:0] slave_q;
	logic [7:0] reg_q;
	logic [7:0] data_q;
	logic       err_q;
	logic [7:0] dout_q;
	logic [1:0] byte_idx_q;
	i2cmra_pkg::out_beat_t res_q;
	logic res_valid_q;

	logic [4:0] ph, ph_n;
	logic [3:0] bc_n;
	logic [7:0] sh_n;
	logic [9:0] wt_n;
	logic       rd_n;
	logic [7:0] sl_n, rg_n, dt_n;
	logic       er_n;
	logic [7:0] do_n;
	logic [1:0] bi_n;
	logic       scl, sda, drv, busy, done, step;
	logic [7:0] load_val;
	logic [1:0] load_idx;
	logic       load;

	assign q_ready = !res_valid_q || out_ready;
	assign step = q_valid && q_ready;
	assign out_data = res_q;
	assign out_valid = res_valid_q;

	always_comb begin
		unique case (load_idx)
			i2cmra_pkg::BI_ADDR: load_val = sl_n;
			i2cmra_pkg::BI_REG: load_val = rg_n;
			i2cmra_pkg::BI_DATA: load_val = dt_n;
			default: load_val = sl_n + 8'd1;
		endcase
	end

	always_comb begin
		ph = (phase_q > i2cmra_pkg::PH_SP_D) ? i2cmra_pkg::PH_IDLE : phase_q;
		bc_n = bit_count_q; sh_n = shift_q; wt_n = wait_q; rd_n = is_read_q;
		sl_n = slave_q; rg_n = reg_q; dt_n = data_q; er_n = err_q; do_n = dout_q;
		bi_n = byte_idx_q;
		scl = 1'b1; sda = 1'b1; drv = 1'b1; done = 1'b0;
		load = 1'b0; load_idx = byte_idx_q;
		if (ph == i2cmra_pkg::PH_IDLE && (q_data.cmd == i2cmra_pkg::CMD_WRITE
				|| q_data.cmd == i2cmra_pkg::CMD_READ)) begin
			rd_n = (q_data.cmd == i2cmra_pkg::CMD_READ);
			sl_n = q_data.slave_addr; rg_n = q_data.reg_addr; dt_n = q_data.write_data;
			er_n = 1'b0; do_n = 8'h00; bi_n = i2cmra_pkg::BI_ADDR; bc_n = 4'd0; wt_n = 10'd0;
			ph = i2cmra_pkg::PH_ST_SETUP;
		end
		busy = (ph != i2cmra_pkg::PH_IDLE);
		ph_n = ph;
		unique case (ph)
			i2cmra_pkg::PH_ST_SETUP: ph_n = i2cmra_pkg::PH_ST_FALL;
			i2cmra_pkg::PH_ST_FALL: begin
				sda = 1'b0; ph_n = i2cmra_pkg::PH_ST_HOLD;
			end
			i2cmra_pkg::PH_ST_HOLD: begin
				scl = 1'b0; sda = 1'b0; load = 1'b1; load_idx = bi_n;
			end
			i2cmra_pkg::PH_TX_LOW: begin
				scl = 1'b0; sda = shift_q[7]; ph_n = i2cmra_pkg::PH_TX_HIGH;
			end
			i2cmra_pkg::PH_TX_HIGH: begin
				sda = shift_q[7];
				sh_n = {shift_q[6:0], 1'b0};
				bc_n = bit_count_q + 4'd1;
				if (bc_n >= 4'd8) begin
					wt_n = 10'd0; ph_n = i2cmra_pkg::PH_ACK_LOW;
				end else ph_n = i2cmra_pkg::PH_TX_LOW;
			end
			i2cmra_pkg::PH_ACK_LOW: begin
				scl = 1'b0; drv = 1'b0; ph_n = i2cmra_pkg::PH_ACK_HIGH;
			end
			i2cmra_pkg::PH_ACK_HIGH: begin
				drv = 1'b0;
				priority if (!q_data.sda_in) ph_n = i2cmra_pkg::PH_ACK_END;
				else if (wait_q >= ack_limit) begin
					er_n = 1'b1; do_n = 8'h00; ph_n = i2cmra_pkg::PH_SP_A;
				end else wt_n = wait_q + 10'd1;
			end
			i2cmra_pkg::PH_ACK_END: begin
				scl = 1'b0; drv = 1'b0;
				unique case (byte_idx_q)
					i2cmra_pkg::BI_ADDR: begin
						load = 1'b1; load_idx = i2cmra_pkg::BI_REG;
					end
					i2cmra_pkg::BI_REG: begin
						if (is_read_q) begin
							bi_n = i2cmra_pkg::BI_RADDR; ph_n = i2cmra_pkg::PH_RS_PREP;
						end else begin
							load = 1'b1; load_idx = i2cmra_pkg::BI_DATA;
						end
					end
					i2cmra_pkg::BI_RADDR: begin
						sh_n = 8'h00; bc_n = 4'd0; ph_n = i2cmra_pkg::PH_RX_LOW;
					end
					default: ph_n = i2cmra_pkg::PH_SP_A;
				endcase
			end
			i2cmra_pkg::PH_RS_PREP: begin
				scl = 1'b0; ph_n = i2cmra_pkg::PH_ST_SETUP;
			end
			i2cmra_pkg::PH_RX_LOW: begin
				scl = 1'b0; drv = 1'b0; ph_n = i2cmra_pkg::PH_RX_HIGH;
			end
			i2cmra_pkg::PH_RX_HIGH: begin
				drv = 1'b0;
				sh_n = {shift_q[6:0], q_data.sda_in};
				bc_n = bit_count_q + 4'd1;
				ph_n = (bc_n >= 4'd8) ? i2cmra_pkg::PH_NACK_LOW : i2cmra_pkg::PH_RX_LOW;
			end
			i2cmra_pkg::PH_NACK_LOW: begin
				scl = 1'b0; ph_n = i2cmra_pkg::PH_NACK_HIGH;
			end
			i2cmra_pkg::PH_NACK_HIGH: begin
				do_n = shift_q; ph_n = i2cmra_pkg::PH_SP_A;
			end
			i2cmra_pkg::PH_SP_A: begin
				scl = 1'b0; ph_n = i2cmra_pkg::PH_SP_B;
			end
			i2cmra_pkg::PH_SP_B: begin
				scl = 1'b0; sda = 1'b0; ph_n = i2cmra_pkg::PH_SP_C;
			end
			i2cmra_pkg::PH_SP_C: begin
				sda = 1'b0; ph_n = i2cmra_pkg::PH_SP_D;
			end
			i2cmra_pkg::PH_SP_D: begin
				done = 1'b1; ph_n = i2cmra_pkg::PH_IDLE;
			end
			default: ph_n = i2cmra_pkg::PH_IDLE;
		endcase
		if (load) begin
			bi_n = load_idx; sh_n = load_val; bc_n = 4'd0; ph_n = i2cmra_pkg::PH_TX_LOW;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q.scl_level <= scl;
			res_q.sda_level <= sda;
			res_q.sda_drive <= drv;
			res_q.busy_res <= busy;
			res_q.done_res <= done;
			res_q.ack_error <= er_n;
			res_q.read_data <= do_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cmra_pkg::PH_IDLE;
			bit_count_q <= 4'd0; shift_q <= 8'd0; wait_q <= 10'd0; is_read_q <= 1'b0;
			slave_q <= 8'd0; reg_q <= 8'd0; data_q <= 8'd0; err_q <= 1'b0;
			dout_q <= 8'd0; byte_idx_q <= 2'd0; res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= ph_n;
				bit_count_q <= bc_n; shift_q <= sh_n; wait_q <= wt_n; is_read_q <= rd_n;
				slave_q <= sl_n; reg_q <= rg_n; data_q <= dt_n; err_q <= er_n;
				dout_q <= do_n; byte_idx_q <= bi_n;
			end
			if (q_ready) res_valid_q <= q_valid;
		end
	end
endmodule
`default_nettype wire

// ===== bench/i2c_master_register_access_test.sv =====
// Testbench for the I2C register access master: directed and random bus ticks, checked
// beat by beat against a tick-level predictor of the transaction sequencer.
// Depends on i2cmra_pkg and i2c_master_register_access.
`default_nettype none
module i2c_master_register_access_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	i2cmra_pkg::in_beat_t in_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	i2cmra_pkg::out_beat_t out_data;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [9:0] cfg_data = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;

	i2c_master_register_access uut (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
		.out_data(out_data), .out_valid(out_valid), .out_ready(out_ready),
		.cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
	);

	always #5 clk = ~clk;

	// Predicted sequencer state.
	logic [9:0] ack_limit;
	logic [4:0] bus_phase;
	logic [3:0] bit_cnt;
	logic [7:0] shifter;
	logic [9:0] high_ticks;
	logic       reading;
	logic [7:0] dev_addr, reg_byte, data_byte;
	logic       nack_seen;
	logic [7:0] rx_byte;
	logic [1:0] byte_sel;

	i2cmra_pkg::out_beat_t expected_beats[$];
	int errors = 0;
	int beats_sent = 0;
	int beats_checked = 0;
	int transfers_done = 0;
	int timeouts_seen = 0;
	int idle_cycles = 0;
	int hold_cycles = 0;
	int sda_high_pct = 30;
	int stall_left = 0;

	function automatic logic [7:0] byte_at(input logic [1:0] sel);
		case (sel)
			i2cmra_pkg::BI_ADDR: return dev_addr;
			i2cmra_pkg::BI_REG: return reg_byte;
			i2cmra_pkg::BI_DATA: return data_byte;
			default: return dev_addr + 8'd1;
		endcase
	endfunction

	function automatic void start_byte(input logic [1:0] sel);
		byte_sel = sel;
		shifter = byte_at(sel);
		bit_cnt = '0;
		bus_phase = i2cmra_pkg::PH_TX_LOW;
	endfunction

	function automatic i2cmra_pkg::out_beat_t bus_tick(input i2cmra_pkg::in_beat_t b);
		i2cmra_pkg::out_beat_t r;
		logic scl, sda, drv, busy, done;
		scl = 1'b1; sda = 1'b1; drv = 1'b1; done = 1'b0;
		if (bus_phase > i2cmra_pkg::PH_SP_D)
			bus_phase = i2cmra_pkg::PH_IDLE;
		if (bus_phase == i2cmra_pkg::PH_IDLE && (b.cmd == i2cmra_pkg::CMD_WRITE
				|| b.cmd == i2cmra_pkg::CMD_READ)) begin
			reading = (b.cmd == i2cmra_pkg::CMD_READ);
			dev_addr = b.slave_addr;
			reg_byte = b.reg_addr;
			data_byte = b.write_data;
			nack_seen = 1'b0;
			rx_byte = '0;
			byte_sel = i2cmra_pkg::BI_ADDR;
			bit_cnt = '0;
			high_ticks = '0;
			bus_phase = i2cmra_pkg::PH_ST_SETUP;
		end
		busy = (bus_phase != i2cmra_pkg::PH_IDLE);
		case (bus_phase)
			i2cmra_pkg::PH_ST_SETUP: bus_phase = i2cmra_pkg::PH_ST_FALL;
			i2cmra_pkg::PH_ST_FALL: begin
				sda = 1'b0;
				bus_phase = i2cmra_pkg::PH_ST_HOLD;
			end
			i2cmra_pkg::PH_ST_HOLD: begin
				scl = 1'b0; sda = 1'b0;
				start_byte(byte_sel);
			end
			i2cmra_pkg::PH_TX_LOW: begin
				scl = 1'b0;
				sda = shifter[7];
				bus_phase = i2cmra_pkg::PH_TX_HIGH;
			end
			i2cmra_pkg::PH_TX_HIGH: begin
				sda = shifter[7];
				shifter = shifter << 1;
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt >= 4'd8) begin
					high_ticks = '0;
					bus_phase = i2cmra_pkg::PH_ACK_LOW;
				end else begin
					bus_phase = i2cmra_pkg::PH_TX_LOW;
				end
			end
			i2cmra_pkg::PH_ACK_LOW: begin
				scl = 1'b0; drv = 1'b0;
				bus_phase = i2cmra_pkg::PH_ACK_HIGH;
			end
			i2cmra_pkg::PH_ACK_HIGH: begin
				drv = 1'b0;
				if (!b.sda_in) begin
					bus_phase = i2cmra_pkg::PH_ACK_END;
				end else if (high_ticks >= ack_limit) begin
					nack_seen = 1'b1;
					rx_byte = '0;
					bus_phase = i2cmra_pkg::PH_SP_A;
				end else begin
					high_ticks = high_ticks + 10'd1;
				end
			end
			i2cmra_pkg::PH_ACK_END: begin
				scl = 1'b0; drv = 1'b0;
				if (byte_sel == i2cmra_pkg::BI_ADDR) begin
					start_byte(i2cmra_pkg::BI_REG);
				end else if (byte_sel == i2cmra_pkg::BI_REG) begin
					if (reading) begin
						byte_sel = i2cmra_pkg::BI_RADDR;
						bus_phase = i2cmra_pkg::PH_RS_PREP;
					end else begin
						start_byte(i2cmra_pkg::BI_DATA);
					end
				end else if (byte_sel == i2cmra_pkg::BI_RADDR) begin
					shifter = '0;
					bit_cnt = '0;
					bus_phase = i2cmra_pkg::PH_RX_LOW;
				end else begin
					bus_phase = i2cmra_pkg::PH_SP_A;
				end
			end
			i2cmra_pkg::PH_RS_PREP: begin
				scl = 1'b0;
				bus_phase = i2cmra_pkg::PH_ST_SETUP;
			end
			i2cmra_pkg::PH_RX_LOW: begin
				scl = 1'b0; drv = 1'b0;
				bus_phase = i2cmra_pkg::PH_RX_HIGH;
			end
			i2cmra_pkg::PH_RX_HIGH: begin
				drv = 1'b0;
				shifter = {shifter[6:0], b.sda_in};
				bit_cnt = bit_cnt + 4'd1;
				bus_phase = (bit_cnt >= 4'd8) ? i2cmra_pkg::PH_NACK_LOW
					: i2cmra_pkg::PH_RX_LOW;
			end
			i2cmra_pkg::PH_NACK_LOW: begin
				scl = 1'b0;
				bus_phase = i2cmra_pkg::PH_NACK_HIGH;
			end
			i2cmra_pkg::PH_NACK_HIGH: begin
				rx_byte = shifter;
				bus_phase = i2cmra_pkg::PH_SP_A;
			end
			i2cmra_pkg::PH_SP_A: begin
				scl = 1'b0;
				bus_phase = i2cmra_pkg::PH_SP_B;
			end
			i2cmra_pkg::PH_SP_B: begin
				scl = 1'b0; sda = 1'b0;
				bus_phase = i2cmra_pkg::PH_SP_C;
			end
			i2cmra_pkg::PH_SP_C: begin
				sda = 1'b0;
				bus_phase = i2cmra_pkg::PH_SP_D;
			end
			i2cmra_pkg::PH_SP_D: begin
				done = 1'b1;
				bus_phase = i2cmra_pkg::PH_IDLE;
			end
			default: bus_phase = i2cmra_pkg::PH_IDLE;
		endcase
		r.scl_level = scl;
		r.sda_level = sda;
		r.sda_drive = drv;
		r.busy_res = busy;
		r.done_res = done;
		r.ack_error = nack_seen;
		r.read_data = rx_byte;
		return r;
	endfunction

	function automatic int random_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_beat(input i2cmra_pkg::in_beat_t b);
		int gap;
		gap = random_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_data <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_beats.push_back(bus_tick(b));
		beats_sent++;
	endtask

	// One tick with the SDA level chosen to suit the predicted phase.
	task automatic send_tick(input logic [1:0] cmd);
		i2cmra_pkg::in_beat_t b;
		b.cmd = cmd;
		b.slave_addr = 8'($urandom_range(0, 255));
		b.reg_addr = 8'($urandom_range(0, 255));
		b.write_data = 8'($urandom_range(0, 255));
		if (bus_phase == i2cmra_pkg::PH_ACK_HIGH)
			b.sda_in = ($urandom_range(0, 99) < sda_high_pct);
		else
			b.sda_in = 1'($urandom_range(0, 1));
		send_beat(b);
	endtask

	task automatic run_transfer(input logic [1:0] cmd, input logic [7:0] dev,
			input logic [7:0] regv, input logic [7:0] datv, input int busy_cmd_pct);
		i2cmra_pkg::in_beat_t b;
		b.cmd = cmd;
		b.slave_addr = dev;
		b.reg_addr = regv;
		b.write_data = datv;
		b.sda_in = 1'($urandom_range(0, 1));
		send_beat(b);
		while (bus_phase != i2cmra_pkg::PH_IDLE) begin
			if ($urandom_range(0, 99) < busy_cmd_pct)
				send_tick(2'($urandom_range(1, 3)));
			else
				send_tick(i2cmra_pkg::CMD_TICK);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_limit(input logic [9:0] value);
		drain();
		@(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		ack_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_extreme_writes();
		sda_high_pct = 0;
		run_transfer(i2cmra_pkg::CMD_WRITE, 8'h00, 8'h00, 8'h00, 0);
		run_transfer(i2cmra_pkg::CMD_WRITE, 8'hFF, 8'hFF, 8'hFF, 0);
		run_transfer(i2cmra_pkg::CMD_WRITE, 8'hA4, 8'h5A, 8'hC3, 0);
	endtask

	task automatic test_reads();
		sda_high_pct = 10;
		run_transfer(i2cmra_pkg::CMD_READ, 8'hFF, 8'h00, 8'h00, 0);
		run_transfer(i2cmra_pkg::CMD_READ, 8'h00, 8'hFF, 8'hFF, 0);
		run_transfer(i2cmra_pkg::CMD_READ, 8'h3C, 8'h81, 8'h7E, 0);
	endtask

	task automatic test_ignored_commands();
		send_tick(i2cmra_pkg::CMD_TICK);
		send_tick(2'd3);
		send_tick(2'd3);
		run_transfer(i2cmra_pkg::CMD_WRITE, 8'h92, 8'h11, 8'hEE, 60);
		run_transfer(i2cmra_pkg::CMD_READ, 8'h92, 8'h11, 8'hEE, 60);
	endtask

	task automatic test_ack_timeout(input logic [9:0] limit);
		write_limit(limit);
		sda_high_pct = 100;
		run_transfer(i2cmra_pkg::CMD_WRITE, 8'h50, 8'h01, 8'h02, 0);
		run_transfer(i2cmra_pkg::CMD_READ, 8'h51, 8'h03, 8'h04, 0);
	endtask

	task automatic test_random(input logic [9:0] limit, input int beats, input int hi_pct);
		int stop_at;
		write_limit(limit);
		sda_high_pct = hi_pct;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0: send_tick($urandom_range(0, 3) == 0 ? 2'd3 : i2cmra_pkg::CMD_TICK);
				1, 2, 3, 4: run_transfer(i2cmra_pkg::CMD_WRITE, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8);
				default: run_transfer(i2cmra_pkg::CMD_READ, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8);
			endcase
		end
	endtask

	task automatic test_backpressure();
		sda_high_pct = 20;
		hold_cycles = 150;
		run_transfer(i2cmra_pkg::CMD_READ, 8'hA0, 8'h10, 8'h00, 5);
		run_transfer(i2cmra_pkg::CMD_WRITE, 8'hA0, 8'h10, 8'h55, 5);
	endtask

	// Receiver: random stalls, plus long hold-offs requested by the tests.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 25) begin
			out_ready <= 1'b0;
			stall_left <= random_gap();
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		i2cmra_pkg::out_beat_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat %h, expected none", $time, out_data);
			end else begin
				e = expected_beats.pop_front();
				check_field("scl_level", e.scl_level, out_data.scl_level);
				check_field("sda_level", e.sda_level, out_data.sda_level);
				check_field("sda_drive", e.sda_drive, out_data.sda_drive);
				check_field("busy_res", e.busy_res, out_data.busy_res);
				check_field("done_res", e.done_res, out_data.done_res);
				check_field("ack_error", e.ack_error, out_data.ack_error);
				check_field("read_data", e.read_data, out_data.read_data);
				beats_checked++;
				if (e.done_res)
					transfers_done++;
				if (e.done_res && e.ack_error)
					timeouts_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("i2c_master_register_access test failed");
			$finish;
		end
	end

	initial begin
		ack_limit = i2cmra_pkg::ACK_LIMIT_RESET;
		bus_phase = i2cmra_pkg::PH_IDLE;
		bit_cnt = '0;
		shifter = '0;
		high_ticks = '0;
		reading = 1'b0;
		dev_addr = '0;
		reg_byte = '0;
		data_byte = '0;
		nack_seen = 1'b0;
		rx_byte = '0;
		byte_sel = i2cmra_pkg::BI_ADDR;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extreme_writes();
		test_reads();
		test_ignored_commands();
		test_backpressure();
		test_ack_timeout(10'd1);
		test_ack_timeout(10'd200);
		test_random(10'd1, 100, 40);
		test_random(10'd1023, 100, 30);
		test_random(10'($urandom_range(2, 20)), 100, 45);
		test_random(i2cmra_pkg::ACK_LIMIT_RESET, 100, 20);
		drain();

		$display("Covered %0d ticks, %0d transfers finished, %0d aborted on acknowledge.",
			beats_checked, transfers_done, timeouts_seen);
		$display("Acknowledge limits 1, 200, 1023, small random and 500 were exercised.");
		if (errors == 0 && expected_beats.size() == 0)
			$display("i2c_master_register_access test passed");
		else
			$display("i2c_master_register_access test failed");
		$finish;
	end
endmodule
`default_nettype wire
